FILE: design/ict_pkg.sv
package ict_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic [1:0] OP_POST    = 2'd0;
    localparam logic [1:0] OP_COLLECT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
    localparam logic [31:0] WAKE_MASK  = 32'h000c_0000;
    localparam logic [31:0] WAKE_FLAG  = 32'h0000_8000;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  entry_index;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [31:0] cause;
        logic        found;
    } rsp_t;

    typedef struct packed {
        logic post;
        logic walk_start;
        logic walk_step;
        logic sweep_start;
        logic sweep_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic rd_nonzero;
        logic sweep_last;
    } sts_t;

    function automatic logic [31:0] remap_total(input logic [31:0] total);
        logic [31:0] t;
        t = (total == ALL_ONES) ? 32'd0 : total;
        if ((t & WAKE_MASK) != 32'd0)
        begin
            t = t | WAKE_FLAG;
        end
        return {t[15:8], 16'd0, t[7:0]};
    endfunction

endpackage

FILE: design/interrupt_cause_table_collector.sv
// Interrupt cause table in a single-port-write, registered-read memory of
// TABLE_ENTRIES words. A collect retires the nonzero entries from the read
// index onward and waits, if need be, for the previous result to be taken: the
// memory read port delivers one entry per cycle through its registered read, and
// the walk stops at the first zero entry (at most one full pass of the ring).
// A clear, and the sweep after reset, zero the memory one entry a cycle,
// during which no request is taken. A finished result waits in an output
// register, so posts keep flowing while it is unread.
module interrupt_cause_table_collector #(
    parameter int TABLE_ENTRIES = ict_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          request_ready,
    input  ict_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ict_pkg::rsp_t rsp
);
    import ict_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ict_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .op            (req.op),
        .request_ready (request_ready),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ict_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

FILE: design/ict_ctrl.sv
module ict_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    op,
    output logic          request_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  ict_pkg::sts_t sts,
    output ict_pkg::cmd_t cmd
);
    import ict_pkg::*;

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;
    logic       out_free;

    assign request_ready = (state_reg == ST_IDLE);
    assign accept        = req_valid && request_ready;
    assign out_free      = !rsp_valid_reg || rsp_ready;
    assign rsp_valid     = rsp_valid_reg;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        cmd.post        = accept && (op == OP_POST);
        cmd.walk_start  = accept && (op == OP_COLLECT);
        cmd.sweep_start = accept && (op == OP_CLEAR);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.walk_start)
                begin
                    state_next = ST_WALK;
                end
                else if (cmd.sweep_start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_WALK:
            begin
                // consume nonzero entries; on the first zero wait for a free output slot
                if (sts.rd_nonzero)
                begin
                    cmd.walk_step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_walk_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_start |=> state_reg == ST_WALK)
        else $error("collect did not start a walk");

    a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) && sts.sweep_last |=> state_reg == ST_IDLE)
        else $error("sweep did not end on last entry");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load_out))
        else $error("result appeared without a load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overwritten");

endmodule

FILE: design/ict_dp.sv
module ict_dp #(
    parameter int TABLE_ENTRIES = ict_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ict_pkg::req_t req,
    input  ict_pkg::cmd_t cmd,
    output ict_pkg::sts_t sts,
    output ict_pkg::rsp_t rsp
);
    import ict_pkg::*;

    localparam int         IW       = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST  = IW'(TABLE_ENTRIES - 1);

    logic [31:0]   mem [TABLE_ENTRIES];
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          post_ok;

    logic [IW-1:0] read_index_reg;
    logic [IW-1:0] read_index_next;
    logic [IW-1:0] nxt_idx;
    logic [IW-1:0] sweep_cnt_reg;
    logic [IW-1:0] sweep_cnt_next;
    logic [31:0]   total_reg;
    logic [31:0]   total_next;
    logic          first_reg;
    logic          first_next;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    assign nxt_idx = (read_index_reg == LAST) ? '0 : read_index_reg + 1'b1;
    assign post_ok = cmd.post && (32'(req.entry_index) < 32'(TABLE_ENTRIES));

    assign wr_en   = post_ok || cmd.walk_step || cmd.sweep_step;
    assign wr_addr = post_ok ? IW'(req.entry_index)
                   : (cmd.sweep_step ? sweep_cnt_reg : read_index_reg);
    assign wr_data = post_ok ? req.entry_value : 32'd0;
    // read ahead so the next entry is ready when this one is retired
    assign rd_addr = cmd.walk_step ? nxt_idx : read_index_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        read_index_next = read_index_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        total_next      = total_reg;
        first_next      = first_reg;
        rsp_next        = rsp_reg;
        if (cmd.sweep_start)
        begin
            read_index_next = '0;
            sweep_cnt_next  = '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_cnt_next = (sweep_cnt_reg == LAST) ? '0 : sweep_cnt_reg + 1'b1;
        end
        if (cmd.walk_start)
        begin
            total_next = 32'd0;
            first_next = 1'b1;
        end
        else if (cmd.walk_step)
        begin
            total_next      = total_reg | rd_data_reg;
            first_next      = 1'b0;
            read_index_next = nxt_idx;
        end
        if (cmd.load_out)
        begin
            rsp_next.cause = remap_total(total_reg);
            rsp_next.found = !first_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg <= '0;
            sweep_cnt_reg  <= '0;
        end
        else
        begin
            read_index_reg <= read_index_next;
            sweep_cnt_reg  <= sweep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        first_reg <= first_next;
        rsp_reg   <= rsp_next;
    end

    assign sts.rd_nonzero = (rd_data_reg != 32'd0);
    assign sts.sweep_last = (sweep_cnt_reg == LAST);
    assign rsp            = rsp_reg;

endmodule

FILE: verif/interrupt_cause_table_collector_tb.sv
module interrupt_cause_table_collector_tb;

    import ict_pkg::*;

    localparam int RING        = TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 8000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 1100;
    localparam int RANDOM_ITEMS = 1050;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class cause_scoreboard;
        logic [31:0] cause_words [RING];
        int unsigned rd_idx;
        rsp_t        pending_causes [$];
        int          fail_count;

        function new();
            foreach (cause_words[i])
            begin
                cause_words[i] = '0;
            end
            rd_idx     = 0;
            fail_count = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fail_count++;
        endtask

        // Advance the table model by one accepted transfer.
        function void note_request(req_t item);
            int unsigned slot;
            int unsigned walked;
            logic [31:0] total;
            logic        hit;
            rsp_t        exp_rsp;
            case (item.op)
                OP_POST:
                begin
                    if (item.entry_index < RING)
                    begin
                        cause_words[item.entry_index] = item.entry_value;
                    end
                end
                OP_CLEAR:
                begin
                    foreach (cause_words[i])
                    begin
                        cause_words[i] = '0;
                    end
                    rd_idx = 0;
                end
                OP_COLLECT:
                begin
                    slot   = rd_idx;
                    total  = '0;
                    walked = 0;
                    hit    = (cause_words[slot] != 0);
                    // stop at the first zero word or after one full lap
                    while (walked < RING && cause_words[slot] != 0)
                    begin
                        total |= cause_words[slot];
                        cause_words[slot] = '0;
                        slot = (slot + 1 == RING) ? 0 : slot + 1;
                        walked++;
                    end
                    rd_idx = slot;
                    if (total == ALL_ONES)
                    begin
                        total = '0;
                    end
                    if (total[19] || total[18])
                    begin
                        total[15] = 1'b1;
                    end
                    exp_rsp.cause = hit ? {total[15:8], 16'h0000, total[7:0]} : '0;
                    exp_rsp.found = hit;
                    pending_causes.push_back(exp_rsp);
                end
                default:
                begin
                end
            endcase
        endfunction

        task check_result(rsp_t got);
            rsp_t exp_rsp;
            if (pending_causes.size() == 0)
            begin
                report($sformatf("cause %h found %b with no collect pending",
                                 got.cause, got.found));
                return;
            end
            exp_rsp = pending_causes.pop_front();
            if (got.cause !== exp_rsp.cause)
            begin
                report($sformatf("cause %h, want %h", got.cause, exp_rsp.cause));
            end
            if (got.found !== exp_rsp.found)
            begin
                report($sformatf("found %b, want %b", got.found, exp_rsp.found));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic request_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    cause_scoreboard sb;
    logic quiet;
    int   hold_requests;
    int   hold_served;
    int   sent;

    interrupt_cause_table_collector #(
        .TABLE_ENTRIES(RING)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .request_ready (request_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Present one request and hold it until the transfer happens.
    task automatic send_op(input logic [1:0] op, input logic [9:0] idx,
                           input logic [31:0] val);
        req_t item;
        item.op          = op;
        item.entry_index = idx;
        item.entry_value = val;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(posedge clk);
        end
        while (!request_ready);
        sb.note_request(item);
        if (op != OP_UNUSED)
        begin
            sent++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_causes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 3))
            0:       return 32'd1 << $urandom_range(0, 31);
            1:       return $urandom & WAKE_MASK;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random short stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        hold_served = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            sb.check_result(rsp);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && request_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int unsigned run_len;
        int unsigned start;
        int unsigned pick;
        logic [31:0] val;
        bit          held;
        bit          paused;

        sb            = new();
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        quiet         = 1'b0;
        hold_requests = 0;
        sent          = 0;
        held          = 1'b0;
        paused        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, all-ones total, wake bits, zero post, wrap-free edges
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_POST, 10'd0, 32'hffff_ffff);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_POST, 10'd1, 32'h0004_0000);
        send_op(OP_POST, 10'd2, 32'h0000_00a5);
        send_op(OP_POST, 10'd3, 32'h0008_1200);
        send_op(OP_COLLECT, 10'h3ff, 32'hffff_ffff);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_POST, 10'd4, 32'd0);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_POST, 10'h3ff, 32'h8000_0001);
        send_op(OP_POST, 10'd4, 32'hffff_00ff);
        send_op(OP_POST, 10'd5, 32'h0000_ff00);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_UNUSED, 10'h2aa, 32'h5555_aaaa);
        send_op(OP_CLEAR, 10'h155, 32'haaaa_5555);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        send_op(OP_POST, 10'd0, 32'h0000_8000);
        send_op(OP_POST, 10'd1, 32'h00f0_0f0f);
        send_op(OP_COLLECT, 10'd0, 32'd0);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (sent > RANDOM_ITEMS - 150);
            if (!held && sent >= 300)
            begin
                held = 1'b1;
                hold_requests++;
            end
            if (!paused && sent >= 650)
            begin
                paused = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // run of posts from the read index, then a collect
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40)
                                                      : $urandom_range(0, 5);
                start = sb.rd_idx;
                for (int k = 0; k < run_len; k++)
                begin
                    val = ($urandom_range(0, 9) == 0) ? 32'd0 : random_word();
                    send_op(OP_POST, 10'((start + k) % RING), val);
                end
                send_op(OP_COLLECT, 10'($urandom), $urandom);
            end
            else if (pick < 85)
            begin
                send_op(OP_POST, 10'($urandom), random_word());
            end
            else if (pick < 93)
            begin
                send_op(OP_COLLECT, 10'($urandom), $urandom);
            end
            else if (pick < 97)
            begin
                send_op(OP_UNUSED, 10'($urandom), $urandom);
            end
            else
            begin
                send_op(OP_CLEAR, 10'($urandom), $urandom);
            end
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
